// ===== rtl/shiu_pkg.sv =====
package shiu_pkg;

    localparam int KEY_BITS    = 32;
    localparam int BUCKET_BITS = 31;
    localparam int DATA_BITS   = 32;
    localparam int INDEX_BITS  = 3;
    localparam int RBITS       = 5;

    typedef enum logic [1:0] {
        MODE_DIV = 2'd0,
        MODE_MUL = 2'd1,
        MODE_UNI = 2'd2
    } hash_mode_t;

    localparam logic [INDEX_BITS-1:0] REG_MODE       = 3'd0;
    localparam logic [INDEX_BITS-1:0] REG_TABLE_BITS = 3'd1;
    localparam logic [INDEX_BITS-1:0] REG_MULTIPLIER = 3'd2;
    localparam logic [INDEX_BITS-1:0] REG_OFFSET     = 3'd3;
    localparam logic [INDEX_BITS-1:0] REG_PRIME      = 3'd4;

    localparam logic [1:0]           RESET_MODE       = 2'd0;
    localparam logic [RBITS-1:0]     RESET_TABLE_BITS = 5'd6;
    localparam logic [DATA_BITS-1:0] RESET_MULTIPLIER = 32'd2654435915;
    localparam logic [DATA_BITS-1:0] RESET_OFFSET     = 32'd0;
    localparam logic [DATA_BITS-1:0] RESET_PRIME      = 32'd67;

    typedef struct packed {
        logic [1:0]           hash_mode;
        logic [RBITS-1:0]     table_bits;
        logic [DATA_BITS-1:0] multiplier;
        logic [DATA_BITS-1:0] offset;
        logic [DATA_BITS-1:0] prime_modulus;
    } cfg_t;

endpackage

// ===== rtl/shiu_front.sv =====
module shiu_front #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  shiu_pkg::cfg_t                 cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [shiu_pkg::KEY_BITS-1:0]  key,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [KEY_WIDTH-1:0]           val
);
    import shiu_pkg::*;

    localparam int SHW = $clog2(KEY_WIDTH + 1) + 1;

    logic                 a_valid_reg;
    logic [KEY_WIDTH-1:0] a_key_reg;
    logic [KEY_WIDTH-1:0] a_prod_reg;
    logic                 b_valid_reg;
    logic [KEY_WIDTH-1:0] b_val_reg;
    logic                 b_ready;

    logic [63:0]          key_ext;
    logic [KEY_WIDTH-1:0] key_w;
    logic [31:0]          key32;
    logic [63:0]          prod;
    logic [63:0]          offset_ext;
    logic [SHW-1:0]       shift;
    logic [KEY_WIDTH-1:0] b_val_next;

    assign key_ext = 64'(key);
    assign key_w   = key_ext[KEY_WIDTH-1:0];
    assign key32   = 32'(key_w);
    assign prod    = 64'(cfg.multiplier) * 64'(key32);

    assign in_ready = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;

    assign offset_ext = 64'(cfg.offset);
    assign shift      = SHW'(KEY_WIDTH) - SHW'(cfg.table_bits);

    always_comb
    begin
        unique case (cfg.hash_mode)
            MODE_MUL:
            begin
                if (SHW'(cfg.table_bits) < SHW'(KEY_WIDTH))
                    b_val_next = a_prod_reg >> shift;
                else
                    b_val_next = a_prod_reg;
            end
            MODE_UNI:
                b_val_next = a_prod_reg + offset_ext[KEY_WIDTH-1:0];
            default:
                b_val_next = a_key_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_ready)
                b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            a_key_reg  <= key_w;
            a_prod_reg <= prod[KEY_WIDTH-1:0];
        end
        if (a_valid_reg && b_ready)
            b_val_reg <= b_val_next;
    end

    assign out_valid = b_valid_reg;
    assign val       = b_val_reg;

endmodule

// ===== rtl/shiu_cell.sv =====
module shiu_cell #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [shiu_pkg::DATA_BITS-1:0] prime,
    input  logic                           div_on,
    input  logic                           prev_valid,
    output logic                           prev_ready,
    input  logic [KEY_WIDTH-1:0]           prev_val,
    input  logic [shiu_pkg::DATA_BITS-1:0] prev_rem,
    output logic                           valid,
    input  logic                           next_ready,
    output logic [KEY_WIDTH-1:0]           val,
    output logic [shiu_pkg::DATA_BITS-1:0] rem
);
    import shiu_pkg::*;

    logic                 valid_reg;
    logic [KEY_WIDTH-1:0] val_reg;
    logic [DATA_BITS-1:0] rem_reg;
    logic [KEY_WIDTH-1:0] val_next;
    logic [DATA_BITS-1:0] rem_next;
    logic [DATA_BITS:0]   trial;
    logic [DATA_BITS:0]   diff;

    assign prev_ready = !valid_reg || next_ready;

    // one restoring step: bring in the next dividend bit, subtract P if it fits
    assign trial = {prev_rem, prev_val[KEY_WIDTH-1]};
    assign diff  = trial - {1'b0, prime};

    always_comb
    begin
        if (div_on)
        begin
            val_next = prev_val << 1;
            rem_next = (trial >= {1'b0, prime}) ? diff[DATA_BITS-1:0]
                                                : trial[DATA_BITS-1:0];
        end
        else
        begin
            val_next = prev_val;
            rem_next = prev_rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (prev_ready)
            valid_reg <= prev_valid;
    end

    always_ff @(posedge clk)
    begin
        if (prev_valid && prev_ready)
        begin
            val_reg <= val_next;
            rem_reg <= rem_next;
        end
    end

    assign valid = valid_reg;
    assign val   = val_reg;
    assign rem   = rem_reg;

endmodule

// ===== rtl/selectable_hash_index_unit_top.sv =====
// Channel  | Handshake            | Payload
// ---------+----------------------+---------------------------------------
// in       | in_valid / in_ready  | key [31:0]
// out      | out_valid / out_ready| bucket [30:0]
// cfg      | cfg_valid / cfg_ready| cfg_index [2:0], cfg_data [31:0]
//
// One word per cycle unless out_ready stalls the pipe. The path runs through
// the multiply and select stages and a chain of KEY_WIDTH restoring mod-P cells.
// Reset clears all valid flags and loads the register defaults.
// Each stage holds while its successor is full; ready ripples back stage by
// stage, so bubbles close up. cfg_ready is always high.
module selectable_hash_index_unit_top #(
    parameter int KEY_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [shiu_pkg::INDEX_BITS-1:0] cfg_index,
    input  logic [shiu_pkg::DATA_BITS-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [shiu_pkg::KEY_BITS-1:0]   key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [shiu_pkg::BUCKET_BITS-1:0] bucket
);
    import shiu_pkg::*;

    cfg_t cfg_reg;
    logic div_on;

    logic                 c_valid [0:KEY_WIDTH];
    logic                 c_ready [0:KEY_WIDTH];
    logic [KEY_WIDTH-1:0] c_val   [0:KEY_WIDTH];
    logic [DATA_BITS-1:0] c_rem   [0:KEY_WIDTH];

    logic                   out_valid_reg;
    logic [BUCKET_BITS-1:0] bucket_reg;
    logic [BUCKET_BITS-1:0] bucket_next;
    logic [63:0]            hash_wide;
    logic [DATA_BITS-1:0]   mask_full;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hash_mode     <= RESET_MODE;
            cfg_reg.table_bits    <= RESET_TABLE_BITS;
            cfg_reg.multiplier    <= RESET_MULTIPLIER;
            cfg_reg.offset        <= RESET_OFFSET;
            cfg_reg.prime_modulus <= RESET_PRIME;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:       cfg_reg.hash_mode     <= cfg_data[1:0];
                REG_TABLE_BITS: cfg_reg.table_bits    <= cfg_data[RBITS-1:0];
                REG_MULTIPLIER: cfg_reg.multiplier    <= cfg_data;
                REG_OFFSET:     cfg_reg.offset        <= cfg_data;
                REG_PRIME:      cfg_reg.prime_modulus <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign div_on = (cfg_reg.hash_mode == MODE_UNI) && (cfg_reg.prime_modulus != '0);

    shiu_front #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .key       (key),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .val       (c_val[0])
    );

    assign c_rem[0] = '0;

    for (genvar i = 0; i < KEY_WIDTH; i++)
    begin : g_cell
        shiu_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .prime      (cfg_reg.prime_modulus),
            .div_on     (div_on),
            .prev_valid (c_valid[i]),
            .prev_ready (c_ready[i]),
            .prev_val   (c_val[i]),
            .prev_rem   (c_rem[i]),
            .valid      (c_valid[i+1]),
            .next_ready (c_ready[i+1]),
            .val        (c_val[i+1]),
            .rem        (c_rem[i+1])
        );
    end

    assign c_ready[KEY_WIDTH] = !out_valid_reg || out_ready;

    assign hash_wide   = div_on ? 64'(c_rem[KEY_WIDTH]) : 64'(c_val[KEY_WIDTH]);
    assign mask_full   = (32'd1 << cfg_reg.table_bits) - 32'd1;
    assign bucket_next = hash_wide[BUCKET_BITS-1:0] & mask_full[BUCKET_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (c_ready[KEY_WIDTH])
            out_valid_reg <= c_valid[KEY_WIDTH];
    end

    always_ff @(posedge clk)
    begin
        if (c_valid[KEY_WIDTH] && c_ready[KEY_WIDTH])
            bucket_reg <= bucket_next;
    end

    assign out_valid = out_valid_reg;
    assign bucket    = bucket_reg;

endmodule
